### rtl/fsel_pkg.sv
// Shared constants, sequencer states and control types for the FAT32 unit selector.
`default_nettype none

package fsel_pkg;

    localparam int VOLUME_BITS = 48;
    localparam int SECTOR_W    = 16;
    localparam int UNIT_W      = 19;
    localparam int SECTOR_LOG_MIN_INT = 9;
    // sector count after dropping the smallest sector shift
    localparam int TOT_W  = VOLUME_BITS - SECTOR_LOG_MIN_INT;
    localparam int NEED_W = TOT_W + 2;
    localparam int LOG_W  = 5;
    localparam int CL_W   = 4;

    localparam int MIN_CLUSTERS     = 65527;
    localparam int MAX_CLUSTERS     = 4177917;
    localparam int RESERVED_SECTORS = 32;

    localparam logic [LOG_W-1:0] SECTOR_LOG_MIN       = LOG_W'(SECTOR_LOG_MIN_INT);
    localparam logic [LOG_W-1:0] SECTOR_LOG_1K        = LOG_W'(10);
    localparam logic [LOG_W-1:0] SECTOR_LOG_2K        = LOG_W'(11);
    localparam logic [LOG_W-1:0] SECTOR_LOG_4K        = LOG_W'(12);
    localparam logic [LOG_W-1:0] SECTOR_LOG_NONE      = LOG_W'(0);
    localparam logic [LOG_W-1:0] UNIT_LOG_LAST        = LOG_W'(18);
    localparam logic [LOG_W-1:0] SMALL_SECTOR_LOG_CAP = LOG_W'(16);

    localparam logic [SECTOR_W-1:0] SECTOR_512  = SECTOR_W'(512);
    localparam logic [SECTOR_W-1:0] SECTOR_1024 = SECTOR_W'(1024);
    localparam logic [SECTOR_W-1:0] SECTOR_2048 = SECTOR_W'(2048);
    localparam logic [SECTOR_W-1:0] SECTOR_4096 = SECTOR_W'(4096);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_LOAD,
        ST_STEP_A,
        ST_STEP_B,
        ST_EVAL,
        ST_DONE
    } fsel_state_t;

    typedef struct packed {
        logic load;
        logic step_a;
        logic step_b;
    } fsel_ctrl_t;

    typedef struct packed {
        logic found;
    } fsel_stat_t;

endpackage

`default_nettype wire

### rtl/fsel_fit_unit.sv
// Binary search engine for the largest cluster count that fits one unit size.
`default_nettype none

module fsel_fit_unit (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire fsel_pkg::fsel_ctrl_t      ctrl,
    input  wire logic [fsel_pkg::TOT_W-1:0] total,
    input  wire logic [fsel_pkg::LOG_W-1:0] sl,
    input  wire logic [fsel_pkg::CL_W-1:0]  cl,
    output fsel_pkg::fsel_stat_t           stat,
    output logic [fsel_pkg::TOT_W-1:0]     count
);
    import fsel_pkg::*;

    logic [TOT_W-1:0]  lo_reg, lo_next;
    logic [TOT_W-1:0]  hi_reg, hi_next;
    logic [TOT_W-1:0]  mid_reg, mid_next;
    logic [TOT_W-1:0]  dec_reg, dec_next;
    logic [TOT_W-1:0]  fat_reg, fat_next;
    logic [TOT_W:0]    sum_odd;
    logic [TOT_W+1:0]  fat_sum;
    logic [TOT_W-1:0]  span;
    logic [NEED_W-1:0] need;
    logic              fits;

    always_comb
    begin
        // mid = (lo + hi + 1) / 2; FAT sectors = ceil(4 * (mid + 2) / sector)
        sum_odd  = {1'b0, lo_reg} + {1'b0, hi_reg} + (TOT_W+1)'(1);
        mid_next = sum_odd[TOT_W:1];
        dec_next = mid_next - TOT_W'(1);
        fat_sum  = {1'b0, sum_odd} + (TOT_W+2)'(2)
                   + ((TOT_W+2)'(1) << (sl - LOG_W'(1)));
        fat_next = TOT_W'(fat_sum >> (sl - LOG_W'(1)));

        span = total - TOT_W'(RESERVED_SECTORS);
        need = NEED_W'(RESERVED_SECTORS) + {1'b0, fat_reg, 1'b0}
               + ({2'b00, mid_reg} << cl);
        fits = (need <= {2'b00, total});

        lo_next = lo_reg;
        hi_next = hi_reg;
        if (ctrl.load)
        begin
            lo_next = '0;
            hi_next = span >> cl;
        end
        else if (ctrl.step_b)
        begin
            if (fits)
            begin
                lo_next = mid_reg;
            end
            else
            begin
                hi_next = dec_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg <= '0;
            hi_reg <= '0;
        end
        else
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.step_a)
        begin
            mid_reg <= mid_next;
            dec_reg <= dec_next;
            fat_reg <= fat_next;
        end
    end

    assign stat.found = (lo_reg >= hi_reg);
    assign count      = lo_reg;

    a_bounds_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        lo_reg <= hi_reg)
        else $error("search bounds crossed");

    a_step_only_open: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.step_a |-> (lo_reg < hi_reg))
        else $error("search step on a closed interval");

    a_load_clears_lo: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load |=> (lo_reg == '0))
        else $error("lower bound not cleared on load");

endmodule

`default_nettype wire

### rtl/fat32_cluster_size_select_core.sv
// Top level: input checks and unit sequencer around the shared search engine.
`default_nettype none

// FAT32 allocation unit selector.
// Command channel: an item (volume_bytes, sector_bytes, volume_limit_bytes)
// is taken at a rising edge with start high and busy low. busy stays high
// until the result has been shown.
// Result channel: unit_bytes is valid for the single cycle in which done is
// high; the receiver cannot stall it, so it is taken at the end of that cycle.
// unit_bytes holds its value afterwards until the next result.
// Sequence: a check state, then for each candidate unit a load state, the
// binary search steps (each a STEP_A then a STEP_B state), a closing STEP_A
// state and an evaluation state, then the done state. The search for a unit
// of 2^k sectors takes at most one step per bit of the largest cluster
// count, the sector count width minus k (38 minus k for 1 KiB sectors on
// 48-bit volumes). Up to nine units are tried on 1 KiB sectors; rejected
// items (bad sector size, empty, oversized, partial or tiny volume) go
// from the check state straight to the done state. A new item is taken
// only once busy has fallen.
// Reset clears the sequencer to idle; no result is pending after reset.
module fat32_cluster_size_select_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [fsel_pkg::VOLUME_BITS-1:0]   volume_bytes,
    input  wire logic [fsel_pkg::SECTOR_W-1:0]      sector_bytes,
    input  wire logic [fsel_pkg::VOLUME_BITS-1:0]   volume_limit_bytes,
    output logic                                    done,
    output logic [fsel_pkg::UNIT_W-1:0]             unit_bytes
);
    import fsel_pkg::*;

    fsel_state_t            state_reg, state_next;
    logic [VOLUME_BITS-1:0] vol_reg, lim_reg;
    logic [SECTOR_W-1:0]    sec_reg;
    logic [LOG_W-1:0]       sl_reg, sl_next;
    logic [LOG_W-1:0]       ul_reg, ul_next;
    logic [TOT_W-1:0]       total_reg, total_next;
    logic [UNIT_W-1:0]      result_reg, result_next;

    logic [LOG_W-1:0]       sl_dec;
    logic [VOLUME_BITS-1:0] sec_mask;
    logic [TOT_W-1:0]       total_calc;
    logic                   item_ok;
    logic [CL_W-1:0]        cl;
    logic                   in_range;
    logic                   last_unit;
    fsel_ctrl_t             ctrl;
    fsel_stat_t             stat;
    logic [TOT_W-1:0]       count;

    fsel_fit_unit u_fit (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .total (total_reg),
        .sl    (sl_reg),
        .cl    (cl),
        .stat  (stat),
        .count (count)
    );

    always_comb
    begin
        case (sec_reg)
            SECTOR_512:  sl_dec = SECTOR_LOG_MIN;
            SECTOR_1024: sl_dec = SECTOR_LOG_1K;
            SECTOR_2048: sl_dec = SECTOR_LOG_2K;
            SECTOR_4096: sl_dec = SECTOR_LOG_4K;
            default:     sl_dec = SECTOR_LOG_NONE;
        endcase
    end

    assign sec_mask   = (VOLUME_BITS'(1) << sl_dec) - VOLUME_BITS'(1);
    assign total_calc = TOT_W'(vol_reg >> sl_dec);
    assign item_ok    = (sl_dec != SECTOR_LOG_NONE) && (vol_reg != '0)
                        && (vol_reg <= lim_reg) && ((vol_reg & sec_mask) == '0)
                        && (total_calc > TOT_W'(RESERVED_SECTORS));

    assign cl        = CL_W'(ul_reg - sl_reg);
    assign in_range  = (count >= TOT_W'(MIN_CLUSTERS)) && (count <= TOT_W'(MAX_CLUSTERS));
    assign last_unit = (ul_reg == UNIT_LOG_LAST)
                       || ((sl_reg == SECTOR_LOG_MIN) && (ul_reg == SMALL_SECTOR_LOG_CAP));

    always_comb
    begin
        state_next  = state_reg;
        sl_next     = sl_reg;
        ul_next     = ul_reg;
        total_next  = total_reg;
        result_next = result_reg;
        ctrl        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                sl_next    = sl_dec;
                ul_next    = sl_dec;
                total_next = total_calc;
                if (item_ok)
                begin
                    state_next = ST_LOAD;
                end
                else
                begin
                    result_next = '0;
                    state_next  = ST_DONE;
                end
            end
            ST_LOAD:
            begin
                ctrl.load  = 1'b1;
                state_next = ST_STEP_A;
            end
            ST_STEP_A:
            begin
                if (stat.found)
                begin
                    state_next = ST_EVAL;
                end
                else
                begin
                    ctrl.step_a = 1'b1;
                    state_next  = ST_STEP_B;
                end
            end
            ST_STEP_B:
            begin
                ctrl.step_b = 1'b1;
                state_next  = ST_STEP_A;
            end
            ST_EVAL:
            begin
                if (in_range)
                begin
                    result_next = UNIT_W'(1) << ul_reg;
                    state_next  = ST_DONE;
                end
                else if (last_unit)
                begin
                    result_next = '0;
                    state_next  = ST_DONE;
                end
                else
                begin
                    // advance to the next larger unit
                    ul_next    = ul_reg + LOG_W'(1);
                    state_next = ST_LOAD;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && start)
        begin
            vol_reg <= volume_bytes;
            lim_reg <= volume_limit_bytes;
            sec_reg <= sector_bytes;
        end
        sl_reg     <= sl_next;
        ul_reg     <= ul_next;
        total_reg  <= total_next;
        result_reg <= result_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = (state_reg == ST_DONE);
    assign unit_bytes = result_reg;

    a_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result shown while idle");

    a_accept_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted item did not start work");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!busy && !done))
        else $error("result strobe longer than one cycle");

    a_unit_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVAL) |-> ((ul_reg >= sl_reg) && (ul_reg <= UNIT_LOG_LAST)))
        else $error("candidate unit out of range");

endmodule

`default_nettype wire
